// File: design/tpa_pkg.sv
package tpa_pkg;

   // Sizes
   localparam int MAX_VERTICES = 65536;
   localparam int VCOUNT_W     = $clog2(MAX_VERTICES + 1);
   localparam int TCOUNT_W     = 17;
   localparam int INDEX_W      = 16;
   localparam int WORD_W       = 32;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Primitive modes
   localparam logic [1:0] MODE_LIST  = 2'd0;
   localparam logic [1:0] MODE_STRIP = 2'd1;
   localparam logic [1:0] MODE_FAN   = 2'd2;

   // Corner numbers
   localparam logic [1:0] CORNER_FIRST = 2'd0;
   localparam logic [1:0] CORNER_LAST  = 2'd2;

   // List-mode phase values (vertex number mod 3)
   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_LAST  = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] pos_x;
      logic [WORD_W-1:0] pos_y;
      logic [WORD_W-1:0] pos_z;
      logic [WORD_W-1:0] pos_w;
      logic [WORD_W-1:0] col_r;
      logic [WORD_W-1:0] col_g;
      logic [WORD_W-1:0] col_b;
      logic [WORD_W-1:0] col_a;
      logic              batch_last;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] tri_index;
      logic [1:0]         corner;
      logic [WORD_W-1:0]  out_x;
      logic [WORD_W-1:0]  out_y;
      logic [WORD_W-1:0]  out_z;
      logic [WORD_W-1:0]  out_w;
      logic [WORD_W-1:0]  out_r;
      logic [WORD_W-1:0]  out_g;
      logic [WORD_W-1:0]  out_b;
      logic [WORD_W-1:0]  out_a;
      logic               run_end;
   } rsp_type;

   // One vertex worth of payload words
   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] r;
      logic [WORD_W-1:0] g;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] a;
   } vertex_type;

   // Work handed from front to back: a triangle, a padding repeat, or both
   typedef struct packed {
      logic               has_tri;
      logic               has_pad;
      logic [INDEX_W-1:0] tri_index;
      logic [INDEX_W-1:0] pad_index;
      vertex_type         corner_a;
      vertex_type         corner_b;
      vertex_type         corner_c;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      BACK_FIRST,
      BACK_PAD
   } back_state_type;

endpackage

// File: design/triangle_primitive_assembler_unit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  tpa_pkg::req_type, one vertex
// rsp       out        rsp_valid/rsp_ready  tpa_pkg::rsp_type, one triangle corner
// csr       in         csr_wr_en            csr_wr_data, primitive mode
//
// A vertex is classified in the cycle it transfers; each triangle then leaves as three
// corners, one per cycle from the back-end sequencer unless rsp_ready holds it back.
// Vertices that form no triangle and add no padding are not queued.
// The two-entry job queue lets the front keep taking vertices while the output stalls.
// Synchronous reset clears counters, mode, queue and the output valid.
module triangle_primitive_assembler_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  tpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tpa_pkg::rsp_type rsp_data
);

   tpa_pkg::queue_status_type q_status;
   tpa_pkg::job_type          push_job;
   tpa_pkg::job_type          head_job;
   logic                      push;
   logic                      pop;

   // classification and vertex history
   tpa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_status    (q_status),
      .push        (push),
      .push_job    (push_job)
   );

   // job queue between the two halves
   tpa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // corner sequencer and output register
   tpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/tpa_front.sv
module tpa_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tpa_pkg::req_type          req_data,
   input  tpa_pkg::queue_status_type q_status,
   output logic                      push,
   output tpa_pkg::job_type          push_job
);

   logic [1:0]                   mode_ff;
   logic [tpa_pkg::VCOUNT_W-1:0] vcount_ff, vcount_in;
   logic [tpa_pkg::TCOUNT_W-1:0] tcount_ff, tcount_in;
   logic [1:0]                   phase_ff, phase_in;
   tpa_pkg::vertex_type          pivot_ff, older_ff, newer_ff;
   tpa_pkg::vertex_type          last_a_ff, last_b_ff, last_c_ff;

   tpa_pkg::vertex_type          vert;
   tpa_pkg::vertex_type          sel_a, sel_b;
   logic                         accept;
   logic                         counted;
   logic                         formed;
   logic [tpa_pkg::TCOUNT_W-1:0] tcount_next;
   logic                         has_pad;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   assign vert = '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z,
                   w: req_data.pos_w, r: req_data.col_r, g: req_data.col_g,
                   b: req_data.col_b, a: req_data.col_a};

   assign counted = vcount_ff < tpa_pkg::VCOUNT_W'(tpa_pkg::MAX_VERTICES);

   // classify the vertex against the mode in force
   always_comb begin
      formed = 1'b0;
      sel_a  = older_ff;
      sel_b  = newer_ff;
      unique case (mode_ff)
         tpa_pkg::MODE_LIST: begin
            formed = (phase_ff == tpa_pkg::PHASE_LAST);
         end
         tpa_pkg::MODE_STRIP: begin
            formed = (vcount_ff > tpa_pkg::VCOUNT_W'(1));
            if (vcount_ff[0]) begin
               sel_a = newer_ff;
               sel_b = older_ff;
            end
         end
         tpa_pkg::MODE_FAN: begin
            formed = (vcount_ff > tpa_pkg::VCOUNT_W'(1));
            sel_a  = pivot_ff;
         end
         default: formed = 1'b0;
      endcase
      formed = formed && counted;
   end

   assign tcount_next = formed ? tcount_ff + tpa_pkg::TCOUNT_W'(1) : tcount_ff;
   assign has_pad     = req_data.batch_last && tcount_next[0];

   // job for the back end; padding repeats the triangle just formed or the stored one
   always_comb begin
      push_job.has_tri   = formed;
      push_job.has_pad   = has_pad;
      push_job.tri_index = tcount_ff[tpa_pkg::INDEX_W-1:0];
      push_job.pad_index = tcount_next[tpa_pkg::INDEX_W-1:0];
      if (formed) begin
         push_job.corner_a = sel_a;
         push_job.corner_b = sel_b;
         push_job.corner_c = vert;
      end else begin
         push_job.corner_a = last_a_ff;
         push_job.corner_b = last_b_ff;
         push_job.corner_c = last_c_ff;
      end
   end

   assign push = accept && (formed || has_pad);

   // counter next values
   always_comb begin
      vcount_in = vcount_ff;
      tcount_in = tcount_ff;
      phase_in  = phase_ff;
      if (accept) begin
         if (req_data.batch_last) begin
            vcount_in = '0;
            tcount_in = '0;
            phase_in  = tpa_pkg::PHASE_FIRST;
         end else if (counted) begin
            vcount_in = vcount_ff + tpa_pkg::VCOUNT_W'(1);
            tcount_in = tcount_next;
            phase_in  = (phase_ff == tpa_pkg::PHASE_LAST) ? tpa_pkg::PHASE_FIRST
                                                          : phase_ff + 2'd1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= tpa_pkg::MODE_LIST;
         vcount_ff <= '0;
         tcount_ff <= '0;
         phase_ff  <= tpa_pkg::PHASE_FIRST;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         vcount_ff <= vcount_in;
         tcount_ff <= tcount_in;
         phase_ff  <= phase_in;
      end
   end

   // vertex stores
   always_ff @(posedge clock) begin
      if (accept && counted) begin
         if (vcount_ff == '0) begin
            pivot_ff <= vert;
         end
         older_ff <= newer_ff;
         newer_ff <= vert;
         if (formed) begin
            last_a_ff <= sel_a;
            last_b_ff <= sel_b;
            last_c_ff <= vert;
         end
      end
   end

endmodule

// File: design/tpa_queue.sv
module tpa_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tpa_pkg::job_type          push_job,
   input  logic                      pop,
   output tpa_pkg::job_type          head_job,
   output tpa_pkg::queue_status_type q_status
);

   tpa_pkg::job_type             entries_ff [tpa_pkg::QUEUE_DEPTH];
   logic [tpa_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tpa_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tpa_pkg::QCOUNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == tpa_pkg::QCOUNT_W'(tpa_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = entries_ff[rd_ptr_ff];

   // pointer and occupancy updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tpa_pkg::QPTR_W'(tpa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + tpa_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tpa_pkg::QPTR_W'(tpa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + tpa_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + tpa_pkg::QCOUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tpa_pkg::QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: design/tpa_back.sv
module tpa_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tpa_pkg::job_type          head_job,
   input  tpa_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tpa_pkg::rsp_type          rsp_data
);

   tpa_pkg::back_state_type state_ff, state_in;
   logic [1:0]              corner_ff, corner_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tpa_pkg::rsp_type        rsp_data_ff;

   logic                    advance;
   logic                    emit;
   logic                    pad_pass;
   logic                    last_corner;
   logic                    job_done;
   tpa_pkg::vertex_type     sel_vert;
   tpa_pkg::rsp_type        next_rsp;

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign emit        = advance && !q_status.empty;
   assign last_corner = (corner_ff == tpa_pkg::CORNER_LAST);

   // next state
   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      if (emit) begin
         if (last_corner) begin
            corner_in = tpa_pkg::CORNER_FIRST;
            state_in  = job_done ? tpa_pkg::BACK_FIRST : tpa_pkg::BACK_PAD;
         end else begin
            corner_in = corner_ff + 2'd1;
         end
      end
   end

   // outputs of the sequencer
   always_comb begin
      pad_pass = (state_ff == tpa_pkg::BACK_PAD) || !head_job.has_tri;
      job_done = last_corner && (pad_pass || !head_job.has_pad);
      pop      = emit && job_done;
      unique case (corner_ff)
         2'd0:    sel_vert = head_job.corner_a;
         2'd1:    sel_vert = head_job.corner_b;
         default: sel_vert = head_job.corner_c;
      endcase
      next_rsp.tri_index = pad_pass ? head_job.pad_index : head_job.tri_index;
      next_rsp.corner    = corner_ff;
      next_rsp.out_x     = sel_vert.x;
      next_rsp.out_y     = sel_vert.y;
      next_rsp.out_z     = sel_vert.z;
      next_rsp.out_w     = sel_vert.w;
      next_rsp.out_r     = sel_vert.r;
      next_rsp.out_g     = sel_vert.g;
      next_rsp.out_b     = sel_vert.b;
      next_rsp.out_a     = sel_vert.a;
      next_rsp.run_end   = job_done;
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpa_pkg::BACK_FIRST;
         corner_ff    <= tpa_pkg::CORNER_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= next_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
